/* design/button_debounce_long_press_repeat_defines.svh */
// Assertion macros shared by the verification files of the button debouncer.
// No dependencies; include by bare file name.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_REPEAT_DEFINES_SVH

// Antecedent at one edge implies consequent at the next, outside reset.
`define BDLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent holds in the cycle after any reset cycle.
`define BDLP_ASSERT_AFTER_RESET(lbl, clk, rst, cons, msg) \
  lbl: assert property (@(posedge clk) (rst) |=> (cons)) else $error(msg);

`endif

/* design/bdlp_pkg.sv */
// Shared types and constants for the button debouncer with long press and repeat.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int NUM_KEYS  = 4;
  localparam int NUM_SLOTS = 2 * NUM_KEYS;
  localparam int CNT_W     = $clog2(NUM_KEYS + 1);
  localparam int KEY_W     = 2;
  localparam int TICK_W    = 32;
  localparam int SEQ_W     = 32;
  localparam int DB_W      = 4;
  localparam int IVL_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS     = 2'd2;

  localparam logic [DB_W-1:0]  DEBOUNCE_RESET = 4'd2;
  localparam logic [IVL_W-1:0] LONG_RESET     = 16'd500;
  localparam logic [IVL_W-1:0] REPEAT_RESET   = 16'd200;

  typedef enum logic [2:0] {
    EV_PRESS   = 3'd0,
    EV_RELEASE = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_REPEAT  = 3'd4
  } ev_type_t;

  typedef struct packed {
    logic [DB_W-1:0]  debounce_count;
    logic [IVL_W-1:0] long_press_ticks;
    logic [IVL_W-1:0] repeat_ticks;
  } cfg_t;

  typedef struct packed {
    logic [TICK_W-1:0]   now_tick;
    logic [NUM_KEYS-1:0] button_levels;
  } poll_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic [2:0]       event_type;
    logic [SEQ_W-1:0] sequence_number;
    logic             last_of_poll;
  } event_t;

  // What one lane found for its key on the current poll.
  typedef struct packed {
    logic     press;
    logic     ev0_valid;
    ev_type_t ev0_type;
    logic     ev1_valid;
    ev_type_t ev1_type;
  } lane_ev_t;

endpackage

/* design/bdlp_lane.sv */
// One key lane: debounce counter, stable level and hold timing for a single button.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [bdlp_pkg::TICK_W-1:0] now_tick,
  input  logic                      level,
  input  bdlp_pkg::cfg_t            cfg,
  output bdlp_pkg::lane_ev_t        result
);

  logic                        raw_seen, raw_seen_next;
  logic                        stable, stable_next;
  logic [bdlp_pkg::DB_W-1:0]   count, count_next;
  logic [bdlp_pkg::TICK_W-1:0] start_time, start_time_next;
  logic [bdlp_pkg::TICK_W-1:0] repeat_time, repeat_time_next;
  logic                        long_sent, long_sent_next;

  logic                        raw;
  logic                        settled;
  logic [bdlp_pkg::TICK_W-1:0] held, since_repeat;

  assign raw          = ~level;
  assign held         = now_tick - start_time;
  assign since_repeat = now_tick - repeat_time;

  always_comb begin
    raw_seen_next    = raw_seen;
    stable_next      = stable;
    count_next       = count;
    start_time_next  = start_time;
    repeat_time_next = repeat_time;
    long_sent_next   = long_sent;
    result           = '0;
    result.ev0_type  = bdlp_pkg::EV_PRESS;
    result.ev1_type  = bdlp_pkg::EV_RELEASE;

    if (raw == raw_seen) begin
      if (count < cfg.debounce_count) count_next = count + 1'b1;
    end else begin
      raw_seen_next = raw;
      count_next    = bdlp_pkg::DB_W'(1);
    end
    settled = !(count_next < cfg.debounce_count);

    if (settled) begin
      if (stable != raw) begin
        stable_next = raw;
        if (raw) begin
          start_time_next  = now_tick;
          repeat_time_next = now_tick;
          long_sent_next   = 1'b0;
          result.press     = 1'b1;
          result.ev0_valid = 1'b1;
          result.ev0_type  = bdlp_pkg::EV_PRESS;
        end else begin
          // short goes out first, unless a long press was already reported
          result.ev0_valid = !long_sent;
          result.ev0_type  = bdlp_pkg::EV_SHORT;
          result.ev1_valid = 1'b1;
          result.ev1_type  = bdlp_pkg::EV_RELEASE;
        end
      end else if (stable) begin
        if (!long_sent) begin
          if (held >= {{(bdlp_pkg::TICK_W-bdlp_pkg::IVL_W){1'b0}}, cfg.long_press_ticks}) begin
            long_sent_next   = 1'b1;
            repeat_time_next = now_tick;
            result.ev0_valid = 1'b1;
            result.ev0_type  = bdlp_pkg::EV_LONG;
          end
        end else if (since_repeat >=
                     {{(bdlp_pkg::TICK_W-bdlp_pkg::IVL_W){1'b0}}, cfg.repeat_ticks}) begin
          repeat_time_next = now_tick;
          result.ev0_valid = 1'b1;
          result.ev0_type  = bdlp_pkg::EV_REPEAT;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen    <= 1'b0;
      stable      <= 1'b0;
      count       <= bdlp_pkg::DEBOUNCE_RESET;
      start_time  <= '0;
      repeat_time <= '0;
      long_sent   <= 1'b0;
    end else if (accept) begin
      raw_seen    <= raw_seen_next;
      stable      <= stable_next;
      count       <= count_next;
      start_time  <= start_time_next;
      repeat_time <= repeat_time_next;
      long_sent   <= long_sent_next;
    end
  end

endmodule

/* design/bdlp_merge.sv */
// Merge stage: numbers lane events with the shared press count, buffers them
// in slots and sends them out, one beat per cycle while out_ready allows, through an output register.
// Depends on bdlp_pkg.
`timescale 1ns / 1ps

module bdlp_merge (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    accept,
  input  bdlp_pkg::lane_ev_t [bdlp_pkg::NUM_KEYS-1:0] lanes,
  output logic                                    take,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output bdlp_pkg::event_t                        out_data
);

  logic [bdlp_pkg::SEQ_W-1:0]   seq_base;
  logic [bdlp_pkg::NUM_SLOTS-1:0] pend, pend_new, pend_left;
  logic [2:0]                   slot_type [bdlp_pkg::NUM_SLOTS];
  logic [bdlp_pkg::SEQ_W-1:0]   slot_seq  [bdlp_pkg::NUM_SLOTS];
  logic [bdlp_pkg::SEQ_W-1:0]   lane_seq  [bdlp_pkg::NUM_KEYS];
  logic [bdlp_pkg::CNT_W-1:0]   run;

  logic [bdlp_pkg::NUM_SLOTS-1:0] sel;
  logic [2:0]                   sel_type;
  logic [bdlp_pkg::SEQ_W-1:0]   sel_seq;
  logic [bdlp_pkg::KEY_W-1:0]   sel_key;
  logic                         load, sel_last;

  // press count up to and including each lane
  always_comb begin
    run = '0;
    for (int i = 0; i < bdlp_pkg::NUM_KEYS; i++) begin
      run         = run + bdlp_pkg::CNT_W'(lanes[i].press);
      lane_seq[i] = seq_base + bdlp_pkg::SEQ_W'(run);
      pend_new[2*i]   = lanes[i].ev0_valid;
      pend_new[2*i+1] = lanes[i].ev1_valid;
    end
  end

  // lowest pending slot goes next
  always_comb begin
    sel      = '0;
    sel_type = '0;
    sel_seq  = '0;
    sel_key  = '0;
    for (int j = bdlp_pkg::NUM_SLOTS - 1; j >= 0; j--) begin
      if (pend[j]) begin
        sel      = '0;
        sel[j]   = 1'b1;
        sel_type = slot_type[j];
        sel_seq  = slot_seq[j];
        sel_key  = bdlp_pkg::KEY_W'(j / 2);
      end
    end
  end

  assign load      = (pend != '0) && (!out_valid || out_ready);
  assign pend_left = load ? (pend & ~sel) : pend;
  assign sel_last  = (pend & ~sel) == '0;
  assign take      = (pend_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_base  <= '0;
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        seq_base <= seq_base + bdlp_pkg::SEQ_W'(run);
        pend     <= pend_new;
      end else begin
        pend <= pend_left;
      end
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < bdlp_pkg::NUM_KEYS; i++) begin
        slot_type[2*i]   <= lanes[i].ev0_type;
        slot_type[2*i+1] <= lanes[i].ev1_type;
        slot_seq[2*i]    <= lane_seq[i];
        slot_seq[2*i+1]  <= lane_seq[i];
      end
    end
    if (load) begin
      out_data.key_index       <= sel_key;
      out_data.event_type      <= sel_type;
      out_data.sequence_number <= sel_seq;
      out_data.last_of_poll    <= sel_last;
    end
  end

endmodule

/* design/button_debounce_long_press_repeat.sv */
// Top level of the button debouncer with long press and auto-repeat events.
// Holds the configuration registers; instantiates bdlp_lane per key and bdlp_merge.
// Depends on bdlp_pkg.
//
//   port group   dir  handshake                 beat
//   in_*         in   in_valid / in_ready       one poll: now_tick, button_levels
//   out_*        out  out_valid / out_ready     one event: key, type, seq, last flag
//   cfg_*        in   cfg_write (no wait)       one register write by index
//
// All key lanes evaluate a poll in the cycle it is accepted; events then leave the
// slot buffer at one beat per cycle while out_ready holds. The next poll is taken in
// the cycle its predecessor's last event enters the output register, or at once when
// nothing is pending. Reset is synchronous. A stalled output holds its beat and lets
// the slot buffer fill up to one poll.
`timescale 1ns / 1ps

module button_debounce_long_press_repeat (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bdlp_pkg::poll_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bdlp_pkg::event_t                  out_data,
  input  logic                              cfg_write,
  input  logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bdlp_pkg::CFG_DAT_W-1:0]    cfg_data
);

  bdlp_pkg::cfg_t                             cfg;
  bdlp_pkg::lane_ev_t [bdlp_pkg::NUM_KEYS-1:0] lanes;
  logic                                       accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_count   <= bdlp_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks <= bdlp_pkg::LONG_RESET;
      cfg.repeat_ticks     <= bdlp_pkg::REPEAT_RESET;
    end else if (cfg_write) begin
      // unknown index: drop the write
      unique case (cfg_index)
        bdlp_pkg::REG_DEBOUNCE_COUNT:   cfg.debounce_count   <= cfg_data[bdlp_pkg::DB_W-1:0];
        bdlp_pkg::REG_LONG_PRESS_TICKS: cfg.long_press_ticks <= cfg_data[bdlp_pkg::IVL_W-1:0];
        bdlp_pkg::REG_REPEAT_TICKS:     cfg.repeat_ticks     <= cfg_data[bdlp_pkg::IVL_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < bdlp_pkg::NUM_KEYS; k++) begin : g_lane
    bdlp_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .accept   (accept),
      .now_tick (in_data.now_tick),
      .level    (in_data.button_levels[k]),
      .cfg      (cfg),
      .result   (lanes[k])
    );
  end

  bdlp_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .lanes     (lanes),
    .take      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/bdlp_checker.sv */
// Port-level checks for the button debouncer, bound to the top level.
// Depends on bdlp_pkg and button_debounce_long_press_repeat_defines.svh.
`timescale 1ns / 1ps
`include "button_debounce_long_press_repeat_defines.svh"

module bdlp_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input bdlp_pkg::event_t               out_data
);

  `BDLP_ASSERT_AFTER_RESET(a_idle_after_reset, clk, rst, !out_valid, "output valid after reset")

  `BDLP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled output beat changed")

  `BDLP_ASSERT_NEXT(a_busy_means_output, clk, rst, !in_ready, out_valid, "input stalled with no beat on the output")

  `BDLP_ASSERT_NEXT(a_poll_continues, clk, rst, out_valid && out_ready && !out_data.last_of_poll, out_valid, "gap inside one poll's events")

endmodule

bind button_debounce_long_press_repeat bdlp_checker u_bdlp_checker (.*);
